### sv/http_request_header_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// HTTP request header parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp: next-cycle check failed");

`endif

### sv/hrp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared types, codes and queue sizing for the parser front and back.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // Result queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input operation codes.
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Special characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    // Method names matched on the fly.
    localparam logic [7:0] GET_TEXT  [3] = '{8'h47, 8'h45, 8'h54};
    localparam logic [7:0] HEAD_TEXT [4] = '{8'h48, 8'h45, 8'h41, 8'h44};

    // Field tags.
    localparam logic [2:0] FIELD_NONE    = 3'd0;
    localparam logic [2:0] FIELD_METHOD  = 3'd1;
    localparam logic [2:0] FIELD_PATH    = 3'd2;
    localparam logic [2:0] FIELD_VERSION = 3'd3;
    localparam logic [2:0] FIELD_HEADER  = 3'd4;

    // Event codes.
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_LINE_DONE = 2'd1;
    localparam logic [1:0] EV_BODY      = 2'd2;
    localparam logic [1:0] EV_READY     = 2'd3;

    // Method codes.
    localparam logic [1:0] MK_OTHER = 2'd0;
    localparam logic [1:0] MK_GET   = 2'd1;
    localparam logic [1:0] MK_HEAD  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_NO_SP_METHOD = 3'd1;
    localparam logic [2:0] ERR_EMPTY_METHOD = 3'd2;
    localparam logic [2:0] ERR_NO_SP_PATH   = 3'd3;
    localparam logic [2:0] ERR_EMPTY_PATH   = 3'd4;
    localparam logic [2:0] ERR_EMPTY_VER    = 3'd5;
    localparam logic [2:0] ERR_BODY         = 3'd6;
    localparam logic [2:0] ERR_TRAILING     = 3'd7;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADER  = 3'd3,
        PH_BODY    = 3'd4,
        PH_READY   = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_field;
        logic       byte_valid;
        logic [1:0] event_kind;
        logic [1:0] method_kind;
        logic [2:0] error_code;
        logic       last_result;
    } t_result;

    // Write strobes from the front into the queue; push1 only with push0.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    typedef struct packed {
        logic               can_accept;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

### sv/hrp_front.sv
// ----------------------------------------------------------------------------
// HTTP request header parser front
// Accepts bytes, tracks the parse state and builds up to two results per item.
// ----------------------------------------------------------------------------
module hrp_front import hrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    output t_push      o_push,
    output t_result    o_slot0,
    output t_result    o_slot1
);

    typedef struct packed {
        logic [2:0] pos;
        logic       gm;
        logic       hm;
    } t_meth;

    t_phase     r_phase, n_phase;
    logic       r_cr, n_cr;
    logic       r_fne, n_fne;
    logic [2:0] r_mpos, n_mpos;
    logic       r_gm, n_gm;
    logic       r_hm, n_hm;
    logic [2:0] r_err, n_err;

    logic       accept;
    logic       emit_a, emit_b;
    logic       done;
    t_result    res_a, res_b;
    t_meth      meth_a, meth_b;

    function automatic t_result make_result(input logic [7:0] b, input logic [2:0] fld,
                                            input logic vld, input logic [1:0] ev,
                                            input logic [1:0] mk, input logic [2:0] err);
        t_result r;
        r.out_byte    = b;
        r.byte_field  = fld;
        r.byte_valid  = vld;
        r.event_kind  = ev;
        r.method_kind = mk;
        r.error_code  = err;
        r.last_result = 1'b0;
        return r;
    endfunction

    // Advance the GET/HEAD match by one method byte; the position saturates at 7.
    function automatic t_meth meth_step(input t_meth m, input logic [7:0] b);
        t_meth r;
        r = m;
        if (m.pos < 3'd3) begin
            if (b != GET_TEXT[m.pos[1:0]]) r.gm = 1'b0;
        end else begin
            r.gm = 1'b0;
        end
        if (m.pos < 3'd4) begin
            if (b != HEAD_TEXT[m.pos[1:0]]) r.hm = 1'b0;
        end else begin
            r.hm = 1'b0;
        end
        if (m.pos != 3'd7) r.pos = m.pos + 3'd1;
        return r;
    endfunction

    function automatic logic [1:0] method_code(input logic [2:0] pos, input logic gm,
                                               input logic hm);
        logic [1:0] r;
        r = MK_OTHER;
        if (gm && pos == 3'd3) begin
            r = MK_GET;
        end else if (hm && pos == 3'd4) begin
            r = MK_HEAD;
        end
        return r;
    endfunction

    function automatic logic [2:0] field_tag(input t_phase ph);
        logic [2:0] r;
        unique case (ph)
            PH_METHOD:  r = FIELD_METHOD;
            PH_PATH:    r = FIELD_PATH;
            PH_VERSION: r = FIELD_VERSION;
            default:    r = FIELD_HEADER;
        endcase
        return r;
    endfunction

    assign accept = i_valid && i_ready;
    assign meth_a = meth_step('{pos: r_mpos, gm: r_gm, hm: r_hm}, CH_CR);

    always_comb begin
        n_phase = r_phase;
        n_cr    = r_cr;
        n_fne   = r_fne;
        n_mpos  = r_mpos;
        n_gm    = r_gm;
        n_hm    = r_hm;
        n_err   = r_err;
        emit_a  = 1'b0;
        emit_b  = 1'b0;
        done    = 1'b0;
        res_a   = '0;
        res_b   = '0;
        meth_b  = meth_step('{pos: r_mpos, gm: r_gm, hm: r_hm}, i_in_byte);
        if (accept) begin
            if (i_op == OP_RESTART) begin
                n_phase = PH_METHOD;
                n_cr    = 1'b0;
                n_fne   = 1'b0;
                n_mpos  = '0;
                n_gm    = 1'b1;
                n_hm    = 1'b1;
                n_err   = ERR_OK;
            end else begin
                unique case (r_phase)
                    PH_ERROR: begin
                        emit_b = 1'b1;
                        res_b  = make_result(i_in_byte, FIELD_NONE, 1'b0, EV_NONE,
                                             MK_OTHER, r_err);
                    end
                    PH_BODY: begin
                        n_err   = ERR_BODY;
                        n_phase = PH_ERROR;
                        n_cr    = 1'b0;
                        emit_b  = 1'b1;
                        res_b   = make_result(i_in_byte, FIELD_NONE, 1'b0, EV_NONE,
                                              MK_OTHER, ERR_BODY);
                    end
                    PH_METHOD, PH_PATH, PH_VERSION, PH_HEADER: begin
                        // A held CR is either the first half of a line end or a data byte.
                        if (r_cr) begin
                            n_cr = 1'b0;
                            if (i_in_byte == CH_LF) begin
                                done   = 1'b1;
                                emit_b = 1'b1;
                                if (r_phase == PH_METHOD || r_phase == PH_PATH) begin
                                    n_err   = (r_phase == PH_METHOD) ? ERR_NO_SP_METHOD
                                                                     : ERR_NO_SP_PATH;
                                    n_phase = PH_ERROR;
                                    res_b   = make_result(CH_LF, FIELD_NONE, 1'b0, EV_NONE,
                                                          MK_OTHER, n_err);
                                end else if (r_phase == PH_VERSION) begin
                                    if (!r_fne) begin
                                        n_err   = ERR_EMPTY_VER;
                                        n_phase = PH_ERROR;
                                        res_b   = make_result(CH_LF, FIELD_NONE, 1'b0,
                                                              EV_NONE, MK_OTHER, n_err);
                                    end else begin
                                        n_phase = PH_HEADER;
                                        n_fne   = 1'b0;
                                        res_b   = make_result(CH_LF, FIELD_NONE, 1'b0,
                                                              EV_LINE_DONE,
                                                              method_code(r_mpos, r_gm, r_hm),
                                                              r_err);
                                    end
                                end else if (r_fne) begin
                                    n_fne = 1'b0;
                                    res_b = make_result(CH_LF, FIELD_NONE, 1'b0, EV_NONE,
                                                        MK_OTHER, r_err);
                                end else if (method_code(r_mpos, r_gm, r_hm) != MK_OTHER) begin
                                    n_phase = PH_READY;
                                    res_b   = make_result(CH_LF, FIELD_NONE, 1'b0, EV_READY,
                                                          MK_OTHER, r_err);
                                end else begin
                                    n_phase = PH_BODY;
                                    res_b   = make_result(CH_LF, FIELD_NONE, 1'b0, EV_BODY,
                                                          MK_OTHER, r_err);
                                end
                            end else begin
                                emit_a = 1'b1;
                                n_fne  = 1'b1;
                                if (r_phase == PH_METHOD) begin
                                    n_mpos = meth_a.pos;
                                    n_gm   = meth_a.gm;
                                    n_hm   = meth_a.hm;
                                end
                                res_a = make_result(CH_CR, field_tag(r_phase), 1'b1,
                                                    EV_NONE, MK_OTHER, r_err);
                            end
                        end
                        if (!done) begin
                            // The method state after the CR byte, if any, feeds this byte.
                            meth_b = meth_step('{pos: n_mpos, gm: n_gm, hm: n_hm}, i_in_byte);
                            if (i_in_byte == CH_CR) begin
                                n_cr = 1'b1;
                            end else if (i_in_byte == CH_SP &&
                                         (r_phase == PH_METHOD || r_phase == PH_PATH)) begin
                                emit_b = 1'b1;
                                if (!n_fne) begin
                                    n_err   = (r_phase == PH_METHOD) ? ERR_EMPTY_METHOD
                                                                     : ERR_EMPTY_PATH;
                                    n_phase = PH_ERROR;
                                    n_cr    = 1'b0;
                                    res_b   = make_result(i_in_byte, FIELD_NONE, 1'b0,
                                                          EV_NONE, MK_OTHER, n_err);
                                end else begin
                                    n_phase = (r_phase == PH_METHOD) ? PH_PATH : PH_VERSION;
                                    n_fne   = 1'b0;
                                    res_b   = make_result(i_in_byte, FIELD_NONE, 1'b0,
                                                          EV_NONE, MK_OTHER, r_err);
                                end
                            end else begin
                                emit_b = 1'b1;
                                n_fne  = 1'b1;
                                if (r_phase == PH_METHOD) begin
                                    n_mpos = meth_b.pos;
                                    n_gm   = meth_b.gm;
                                    n_hm   = meth_b.hm;
                                end
                                res_b = make_result(i_in_byte, field_tag(r_phase), 1'b1,
                                                    EV_NONE, MK_OTHER, r_err);
                            end
                        end
                    end
                    default: begin
                        // Ready phase and the unused phase code: any byte is trailing data.
                        n_err   = ERR_TRAILING;
                        n_phase = PH_ERROR;
                        n_cr    = 1'b0;
                        emit_b  = 1'b1;
                        res_b   = make_result(i_in_byte, FIELD_NONE, 1'b0, EV_NONE,
                                              MK_OTHER, ERR_TRAILING);
                    end
                endcase
            end
        end
        res_a.last_result = !emit_b;
        res_b.last_result = 1'b1;
    end

    assign o_push.push0 = emit_a || emit_b;
    assign o_push.push1 = emit_a && emit_b;
    assign o_slot0      = emit_a ? res_a : res_b;
    assign o_slot1      = res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_cr    <= 1'b0;
            r_fne   <= 1'b0;
            r_mpos  <= '0;
            r_gm    <= 1'b1;
            r_hm    <= 1'b1;
            r_err   <= ERR_OK;
        end else begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_fne   <= n_fne;
            r_mpos  <= n_mpos;
            r_gm    <= n_gm;
            r_hm    <= n_hm;
            r_err   <= n_err;
        end
    end

endmodule

### sv/hrp_back.sv
// ----------------------------------------------------------------------------
// HTTP request header parser back
// Result queue with two write slots and an output register toward the sink.
// ----------------------------------------------------------------------------
module hrp_back import hrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  t_result   i_slot0,
    input  t_result   i_slot1,
    output t_q_status o_status,
    output t_result   o_result,
    output logic      o_valid,
    input  logic      i_ready
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out;
    logic                 pop;
    logic [Q_PTR_W-1:0]   wr_ptr_1;

    assign pop      = (r_count != '0) && (!r_out_valid || i_ready);
    assign wr_ptr_1 = r_wr_ptr + Q_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push.push0) + Q_PTR_W'(i_push.push1);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_push.push0) + Q_CNT_W'(i_push.push1)
                   - Q_CNT_W'(pop);
        if (pop) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) r_mem[r_wr_ptr] <= i_slot0;
        if (i_push.push1) r_mem[wr_ptr_1] <= i_slot1;
        if (pop) r_out <= r_mem[r_rd_ptr];
    end

    // Room for the worst case of two results from the next item.
    assign o_status.can_accept = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign o_status.count      = r_count;
    assign o_result            = r_out;
    assign o_valid             = r_out_valid;

endmodule

### sv/http_request_header_parser_unit.sv
// The first result of an item enters the queue at the edge that accepts it, then moves to the output register.
// Throughput: one byte per cycle while input ready is high; the front updates the parse state in the accepting cycle.
// A CR followed by a byte other than LF or CR yields two results, which leave the output one at a time.
// The four-entry result queue sets the stall point: input ready drops when under two are free.
// Reset: synchronous, active low; it clears the parse state, the queue pointers and count, and the output valid flag.
// ----------------------------------------------------------------------------
// HTTP request header parser unit
// Byte-serial request line and header parser with field tags and event codes.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_unit_assert.svh"

module http_request_header_parser_unit import hrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_byte_field,
    output logic       o_byte_valid,
    output logic [1:0] o_event_kind,
    output logic [1:0] o_method_kind,
    output logic [2:0] o_error_code,
    output logic       o_last_result
);

    t_push     push;
    t_result   slot0, slot1;
    t_result   result;
    t_q_status q_status;

    hrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_ready   (q_status.can_accept),
        .i_op      (i_op),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_slot0   (slot0),
        .o_slot1   (slot1)
    );

    hrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_slot0  (slot0),
        .i_slot1  (slot1),
        .o_status (q_status),
        .o_result (result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready)
    );

    assign o_in_ready    = q_status.can_accept;
    assign o_out_byte    = result.out_byte;
    assign o_byte_field  = result.byte_field;
    assign o_byte_valid  = result.byte_valid;
    assign o_event_kind  = result.event_kind;
    assign o_method_kind = result.method_kind;
    assign o_error_code  = result.error_code;
    assign o_last_result = result.last_result;

    // The queue never holds more than its depth.
    `HRP_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, q_status.count <= Q_CNT_W'(Q_DEPTH))

    // A method code comes only with the request line event.
    `HRP_ASSERT_IMPL(a_method_with_event, i_clk, i_rst_n, o_out_valid && o_method_kind != MK_OTHER, o_event_kind == EV_LINE_DONE)

    // An error result never carries a field byte or an event.
    `HRP_ASSERT_IMPL(a_error_quiet, i_clk, i_rst_n, o_out_valid && o_error_code != ERR_OK, !o_byte_valid && o_event_kind == EV_NONE)

    // With nothing queued, nothing accepted and the output taken, the output goes empty.
    `HRP_ASSERT_NEXT(a_drain, i_clk, i_rst_n, q_status.count == '0 && !(i_in_valid && o_in_ready) && (!o_out_valid || i_out_ready), !o_out_valid)

endmodule
